[hdl/lucas_lehmer_mersenne_test_top_defines.svh]
// Assertion macros shared by the checker of the Lucas-Lehmer block.
`ifndef LUCAS_LEHMER_MERSENNE_TEST_TOP_DEFINES_SVH
`define LUCAS_LEHMER_MERSENNE_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LLM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Lucas-Lehmer block assertion failed");

// Next-cycle implication, disabled during reset.
`define LLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Lucas-Lehmer block assertion failed");

`endif

[hdl/llm_pkg.sv]
// Package with the shared constants of the Lucas-Lehmer block.
package llm_pkg;
    localparam int MAX_P_DEF = 128;
    localparam int DIG_W     = 32;
    localparam int EXP_W     = 8;
    localparam int RES_W     = 64;
endpackage

[hdl/lucas_lehmer_mersenne_test_top.sv]
// Lucas-Lehmer test of 2^p-1 with the residue and square held in two digit memories.
// One word is taken at a time; the next is accepted only once its result has gone to the output
// register. The residue holds DIGS = 2*ceil(MAX_P/64) digits and the product WIDE = 2*DIGS+2,
// and each square is folded back in passes until its high part is zero. The 32x32
// multiplier feeds the product memory through a single read-modify-write path.
// Synchronous active-low reset clears the control state and the output valid flag.
module lucas_lehmer_mersenne_test_top #(
    parameter int MAX_P = llm_pkg::MAX_P_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [llm_pkg::EXP_W-1:0] s_exponent,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_is_prime,
    output logic [llm_pkg::RES_W-1:0] m_residue_low
);
    localparam int LIMBS = (MAX_P + 63) / 64;
    localparam int DIGS  = 2 * LIMBS;
    localparam int WIDE  = 2 * DIGS + 2;
    localparam int DW    = $clog2(DIGS);
    localparam int PW    = $clog2(WIDE);
    localparam int XW    = llm_pkg::DIG_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_MRD  = 4'd3;
    localparam logic [3:0] ST_MMUL = 4'd4;
    localparam logic [3:0] ST_MACC = 4'd5;
    localparam logic [3:0] ST_MTOP = 4'd6;
    localparam logic [3:0] ST_ARD  = 4'd7;
    localparam logic [3:0] ST_AEX  = 4'd8;
    localparam logic [3:0] ST_PRD  = 4'd9;
    localparam logic [3:0] ST_PEX  = 4'd10;
    localparam logic [3:0] ST_FRD  = 4'd11;
    localparam logic [3:0] ST_FEX  = 4'd12;
    localparam logic [3:0] ST_CRD  = 4'd13;
    localparam logic [3:0] ST_CEX  = 4'd14;
    localparam logic [3:0] ST_DONE = 4'd15;

    logic [XW-1:0] s_mem [DIGS];
    logic [XW-1:0] p_mem [WIDE];

    logic [3:0]    state_reg, state_next;
    logic [7:0]    p_reg, p_next;
    logic [PW-1:0] w_reg, w_next;
    logic [4:0]    b_reg, b_next;
    logic [7:0]    iter_reg, iter_next;
    logic [DW-1:0] i_reg, i_next, j_reg, j_next;
    logic [PW-1:0] k_reg, k_next;
    logic [XW-1:0] carry_reg, carry_next;
    logic [63:0]   prod_reg, prod_next;
    logic [XW-1:0] hprev_reg, hprev_next;
    logic          hinz_reg, hinz_next, eqm_reg, eqm_next, zero_reg, zero_next;
    logic [63:0]   res_reg, res_next;
    logic          m_valid_reg, m_valid_next, m_prime_reg, m_prime_next;
    logic [63:0]   m_res_reg, m_res_next;

    logic [XW-1:0] srd0_reg, srd1_reg, prd0_reg, prd1_reg;
    logic [DW-1:0] sa0, sa1, swa;
    logic [PW-1:0] pa0, pa1, pwa;
    logic          swe, pwe;
    logic [XW-1:0] swd, pwd;

    logic [XW-1:0] mask_b, mdig, modm2, lo_dig, hi_word, hi_dig, cp_dig;
    logic          hi_in, k_last;
    logic [PW:0]   hi_idx;
    logic [XW:0]   fsum, asum;
    logic [63:0]   mac_t;
    logic [7:0]    p_clamp;

    always_comb begin
        if (s_exponent < 8'd3) begin
            p_clamp = 8'd3;
        end else if (32'(s_exponent) > MAX_P) begin
            p_clamp = 8'(MAX_P);
        end else begin
            p_clamp = s_exponent;
        end
    end

    assign mask_b  = XW'((33'd1 << b_reg) - 33'd1);
    assign mdig    = (k_reg < w_reg) ? '1 : ((k_reg == w_reg) ? mask_b : '0);
    assign modm2   = (k_reg == '0) ? (mdig & ~32'd2) : mdig;
    assign k_last  = (k_reg == PW'(WIDE - 1));
    assign hi_idx  = (PW+1)'(k_reg) + (PW+1)'(w_reg) + (PW+1)'(1);
    assign hi_in   = (hi_idx < (PW+1)'(WIDE));
    assign hi_word = hi_in ? prd1_reg : '0;
    assign hi_dig  = (b_reg == 5'd0) ? hprev_reg
                   : ((hprev_reg >> b_reg) | (hi_word << (6'd32 - {1'b0, b_reg})));
    assign lo_dig  = (k_reg < w_reg) ? prd0_reg : ((k_reg == w_reg) ? (prd0_reg & mask_b) : '0);
    assign fsum    = (XW+1)'(lo_dig) + (XW+1)'(hi_dig) + (XW+1)'(carry_reg[0]);
    assign asum    = (XW+1)'(prd0_reg) + (XW+1)'(modm2) + (XW+1)'(carry_reg[0]);
    assign mac_t   = prod_reg + 64'(prd0_reg) + 64'(carry_reg);
    assign cp_dig  = eqm_reg ? '0 : prd0_reg;

    assign sa0 = i_reg;
    assign sa1 = j_reg;
    assign pa0 = (state_reg == ST_MRD || state_reg == ST_MMUL || state_reg == ST_MACC)
               ? (PW'(i_reg) + PW'(j_reg)) : k_reg;
    assign pa1 = (state_reg == ST_PRD || state_reg == ST_PEX) ? w_reg
               : (hi_in ? hi_idx[PW-1:0] : '0);

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        w_next       = w_reg;
        b_next       = b_reg;
        iter_next    = iter_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        carry_next   = carry_reg;
        prod_next    = prod_reg;
        hprev_next   = hprev_reg;
        hinz_next    = hinz_reg;
        eqm_next     = eqm_reg;
        zero_next    = zero_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        m_res_next   = m_res_reg;
        swe = 1'b0;
        swa = k_reg[DW-1:0];
        swd = '0;
        pwe = 1'b0;
        pwa = k_reg;
        pwd = '0;
        s_ready = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    p_next     = p_clamp;
                    w_next     = PW'(p_clamp[7:5]);
                    b_next     = p_clamp[4:0];
                    iter_next  = '0;
                    k_next     = '0;
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                swe = 1'b1;
                swd = (k_reg == '0) ? 32'd4 : '0;
                if (k_reg == PW'(DIGS - 1)) begin
                    k_next     = '0;
                    state_next = ST_CLR;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_CLR: begin
                pwe = 1'b1;
                if (k_last) begin
                    i_next     = '0;
                    j_next     = '0;
                    carry_next = '0;
                    state_next = ST_MRD;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_MRD: begin
                state_next = ST_MMUL;
            end
            ST_MMUL: begin
                prod_next  = 64'(srd0_reg) * 64'(srd1_reg);
                state_next = ST_MACC;
            end
            ST_MACC: begin
                pwe        = 1'b1;
                pwa        = PW'(i_reg) + PW'(j_reg);
                pwd        = mac_t[31:0];
                carry_next = mac_t[63:32];
                if (j_reg == DW'(DIGS - 1)) begin
                    state_next = ST_MTOP;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_MTOP: begin
                pwe        = 1'b1;
                pwa        = PW'(i_reg) + PW'(DIGS);
                pwd        = carry_reg;
                carry_next = '0;
                j_next     = '0;
                if (i_reg == DW'(DIGS - 1)) begin
                    k_next     = '0;
                    state_next = ST_ARD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_MRD;
                end
            end
            ST_ARD: begin
                state_next = ST_AEX;
            end
            ST_AEX: begin
                pwe        = 1'b1;
                pwd        = asum[XW-1:0];
                carry_next = XW'(asum[XW]);
                if (k_last) begin
                    k_next     = '0;
                    state_next = ST_PRD;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ARD;
                end
            end
            ST_PRD: begin
                state_next = ST_PEX;
            end
            ST_PEX: begin
                hprev_next = prd1_reg;
                carry_next = '0;
                hinz_next  = 1'b0;
                eqm_next   = 1'b1;
                k_next     = '0;
                state_next = ST_FRD;
            end
            ST_FRD: begin
                state_next = ST_FEX;
            end
            ST_FEX: begin
                pwe        = 1'b1;
                pwd        = fsum[XW-1:0];
                carry_next = XW'(fsum[XW]);
                hinz_next  = hinz_reg | (hi_dig != '0);
                eqm_next   = eqm_reg & (fsum[XW-1:0] == mdig);
                hprev_next = hi_word;
                if (k_last) begin
                    k_next = '0;
                    if (hinz_next) begin
                        state_next = ST_PRD;
                    end else begin
                        zero_next  = 1'b1;
                        state_next = ST_CRD;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FRD;
                end
            end
            ST_CRD: begin
                state_next = ST_CEX;
            end
            ST_CEX: begin
                swe       = 1'b1;
                swd       = cp_dig;
                zero_next = zero_reg & (cp_dig == '0);
                if (k_reg == '0) begin
                    res_next[31:0] = cp_dig;
                end
                if (k_reg == PW'(1)) begin
                    res_next[63:32] = cp_dig;
                end
                if (k_reg == PW'(DIGS - 1)) begin
                    k_next    = '0;
                    iter_next = iter_reg + 1'b1;
                    if (iter_reg + 8'd1 == p_reg - 8'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_CLR;
                    end
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_CRD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_prime_next = zero_reg;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        srd0_reg <= s_mem[sa0];
        srd1_reg <= s_mem[sa1];
        prd0_reg <= p_mem[pa0];
        prd1_reg <= p_mem[pa1];
        if (swe) begin
            s_mem[swa] <= swd;
        end
        if (pwe) begin
            p_mem[pwa] <= pwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            iter_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            iter_reg    <= iter_next;
            m_valid_reg <= m_valid_next;
        end
        w_reg       <= w_next;
        b_reg       <= b_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        carry_reg   <= carry_next;
        prod_reg    <= prod_next;
        hprev_reg   <= hprev_next;
        hinz_reg    <= hinz_next;
        eqm_reg     <= eqm_next;
        zero_reg    <= zero_next;
        res_reg     <= res_next;
        m_prime_reg <= m_prime_next;
        m_res_reg   <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_is_prime    = m_prime_reg;
    assign m_residue_low = m_res_reg;
endmodule

[hdl/llm_checker.sv]
// Port checker for the Lucas-Lehmer block and its bind to the top level.
`include "lucas_lehmer_mersenne_test_top_defines.svh"
module llm_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [llm_pkg::EXP_W-1:0] s_exponent,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_is_prime,
    input logic [llm_pkg::RES_W-1:0] m_residue_low
);
    `LLM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)
    `LLM_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `LLM_ASSERT_IMPL(a_prime_zero, m_valid && m_is_prime, m_residue_low == '0)
    `LLM_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_residue_low) && $stable(m_is_prime))
endmodule

bind lucas_lehmer_mersenne_test_top llm_checker u_llm_checker (.*);

[test/tb_top.sv]
// Testbench for the Lucas-Lehmer Mersenne test block: directed table, random words, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      is_prime;
        logic [llm_pkg::RES_W-1:0] residue_low;
    } ll_result_t;

    typedef struct {
        logic [llm_pkg::EXP_W-1:0] exponent;
        bit                        known;
        logic                      is_prime;
        logic [llm_pkg::RES_W-1:0] residue_low;
    } ll_row_t;

    localparam int N_RANDOM = 516;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [llm_pkg::EXP_W-1:0] s_exponent = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_is_prime;
    logic [llm_pkg::RES_W-1:0] m_residue_low;

    ll_result_t pending_results[$];
    int         error_count = 0;
    int         results_seen = 0;
    int         primes_seen = 0;
    bit         steady = 1'b0;

    lucas_lehmer_mersenne_test_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_exponent    (s_exponent),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_prime    (m_is_prime),
        .m_residue_low (m_residue_low)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic ll_result_t lucas_lehmer(input logic [llm_pkg::EXP_W-1:0] exponent);
        int           p;
        logic [127:0] s;
        logic [259:0] x;
        logic [259:0] hi;
        logic [259:0] mersenne;
        ll_result_t   res;
        p = exponent;
        if (p < 3) p = 3;
        if (p > llm_pkg::MAX_P_DEF) p = llm_pkg::MAX_P_DEF;
        mersenne = (260'd1 << p) - 260'd1;
        s = 128'd4;
        for (int i = 0; i < p - 2; i++) begin
            x = {132'd0, s} * {132'd0, s};
            x = x + mersenne - 260'd2;
            for (int pass = 0; pass < 8; pass++) begin
                hi = x >> p;
                if (hi == '0) break;
                x = (x & mersenne) + hi;
            end
            if (x == mersenne) x = '0;
            s = x[127:0];
        end
        res.is_prime = (s == '0);
        res.residue_low = s[63:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        ll_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_is_prime) primes_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: prime %0b residue %h",
                         $time, m_is_prime, m_residue_low);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_is_prime !== want.is_prime) begin
                    $display("%0t: is_prime expected %0b actual %0b",
                             $time, want.is_prime, m_is_prime);
                    error_count++;
                end
                if (m_residue_low !== want.residue_low) begin
                    $display("%0t: residue_low expected %h actual %h",
                             $time, want.residue_low, m_residue_low);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
    end

    task automatic send_word(input logic [llm_pkg::EXP_W-1:0] exponent, input bit known,
                             input ll_result_t typed);
        s_valid <= 1'b1;
        s_exponent <= exponent;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(known ? typed : lucas_lehmer(exponent));
        if (!steady && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        ll_row_t                   rows[$];
        ll_result_t                typed;
        logic [llm_pkg::EXP_W-1:0] exponent;
        int                        pick;
        int                        wait_cycles;

        rows = '{
            '{8'd0,   1, 1'b1, 64'd0}, '{8'd1,   1, 1'b1, 64'd0},
            '{8'd2,   1, 1'b1, 64'd0}, '{8'd3,   1, 1'b1, 64'd0},
            '{8'd4,   0, 1'b0, 64'd0}, '{8'd5,   1, 1'b1, 64'd0},
            '{8'd7,   1, 1'b1, 64'd0}, '{8'd8,   0, 1'b0, 64'd0},
            '{8'd11,  0, 1'b0, 64'd0}, '{8'd13,  1, 1'b1, 64'd0},
            '{8'd17,  1, 1'b1, 64'd0}, '{8'd19,  1, 1'b1, 64'd0},
            '{8'd23,  0, 1'b0, 64'd0}, '{8'd31,  1, 1'b1, 64'd0},
            '{8'd61,  1, 1'b1, 64'd0}, '{8'd64,  0, 1'b0, 64'd0},
            '{8'd65,  0, 1'b0, 64'd0}, '{8'd89,  1, 1'b1, 64'd0},
            '{8'd107, 1, 1'b1, 64'd0}, '{8'd127, 1, 1'b1, 64'd0},
            '{8'd128, 0, 1'b0, 64'd0}, '{8'd129, 0, 1'b0, 64'd0},
            '{8'd200, 0, 1'b0, 64'd0}, '{8'd255, 0, 1'b0, 64'd0}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            typed.is_prime = rows[i].is_prime;
            typed.residue_low = rows[i].residue_low;
            send_word(rows[i].exponent, rows[i].known, typed);
        end

        // Let the pipeline drain completely before the random words start.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        for (int n = 0; n < N_RANDOM; n++) begin
            steady = (n >= 200 && n < 300);
            pick = $urandom_range(99);
            if (pick < 2) exponent = 8'($urandom_range(0, 2));
            else if (pick < 88) exponent = 8'($urandom_range(3, 24));
            else if (pick < 97) exponent = 8'($urandom_range(25, 100));
            else exponent = 8'($urandom_range(101, 255));
            send_word(exponent, 0, typed);
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        wait_cycles = 0;
        while (wait_cycles < 200) begin
            @(posedge aclk);
            wait_cycles++;
        end

        $display("Covered %0d results (%0d prime) over exponents 0 to 255, with clamping.",
                 results_seen, primes_seen);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #600ms;
        $display("FAILURE");
        $finish;
    end
endmodule

[sim.f]
+incdir+hdl
hdl/llm_pkg.sv
hdl/lucas_lehmer_mersenne_test_top.sv
hdl/llm_checker.sv
test/tb_top.sv
